@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL core of the dispatch table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge, ignored while rst_ni is low.
`define SIDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clk_i edge, reset included.
`define SIDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/sidt_pkg.sv @@
// Package of the service instance dispatch table: widths, defaults and codes.
package sidt_pkg;

  localparam int unsigned NumInstancesDef = 16;
  localparam int unsigned NumServicesDef  = 16;
  localparam int unsigned PerServiceDef   = 8;

  localparam int unsigned KindW   = 2;
  localparam int unsigned IdInW   = 4;
  localparam int unsigned SvcInW  = 4;
  localparam int unsigned HashW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ResIdW  = 5;
  localparam int unsigned TotalW  = 5;

  // result_id value that means no instance
  localparam logic [ResIdW-1:0] NoneId = 5'd16;

  typedef enum logic [KindW-1:0] {
    KIND_START  = 2'd0,
    KIND_READY  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    RES_OK       = 3'd0,
    RES_NO_IDS   = 3'd1,
    RES_CONFLICT = 3'd2,
    RES_WRONG    = 3'd3,
    RES_FULL     = 3'd4
  } res_e;

  typedef enum logic [1:0] {
    INST_FREE     = 2'd0,
    INST_STARTING = 2'd1,
    INST_RUNNING  = 2'd2
  } inst_e;

endpackage

@@ hw/rtl/sidt_in_if.sv @@
// Request channel of the dispatch table: valid, ready and one command item.
interface sidt_in_if
  import sidt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic              use_requested;
  logic [IdInW-1:0]  inst_id;
  logic [SvcInW-1:0] svc_id;
  logic [HashW-1:0]  rss_hash;

  modport source (
    output valid, kind, use_requested, inst_id, svc_id, rss_hash,
    input  ready
  );
  modport sink (
    input  valid, kind, use_requested, inst_id, svc_id, rss_hash,
    output ready
  );
endinterface

@@ hw/rtl/sidt_out_if.sv @@
// Response channel of the dispatch table: valid, ready and one result item.
interface sidt_out_if
  import sidt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ResIdW-1:0]  result_id;
  logic [TotalW-1:0]  running_total;

  modport source (
    output valid, status, result_id, running_total,
    input  ready
  );
  modport sink (
    input  valid, status, result_id, running_total,
    output ready
  );
endinterface

@@ hw/rtl/sidt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sidt_ram #(
  parameter  int unsigned Width = 4,
  parameter  int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/service_instance_dispatch_table_core.sv @@
// Top level of the service instance dispatch table with its sequencer.
//
// Usage: commands enter on req_i (start, ready, stop, lookup) and each
// command gives exactly one result on rsp_o. Both channels transfer when
// valid and ready are high at a rising clk_i edge.
// req_i.ready is high only while the sequencer is idle; one command is in
// work at a time. The result sits in an output register, so a new command
// is taken while an earlier result still waits for rsp_o.ready.
// Sequencer steps from request transfer to result valid:
//   start with requested id, ready, failed checks, empty lookup: decode only
//   start with allocation: one status probe per id from the pointer on, up to
//     the first id not running or the last id; none once the pointer is exhausted
//   stop: one member RAM read and compare per list entry searched, then a
//     read and a write per entry moved up through the single RAM read port
//   lookup: a 32-step restoring remainder then one member RAM read
// Reset (rst_ni low, asynchronous) frees all instances, empties all lists
// and clears the pointer and running count; the member RAM keeps its data.
// A stalled receiver holds the result and the next command waits in its
// final step until the output register frees.
`include "assert_macros.svh"

module service_instance_dispatch_table_core
  import sidt_pkg::*;
#(
  parameter int unsigned NumInstances = NumInstancesDef,
  parameter int unsigned NumServices  = NumServicesDef,
  parameter int unsigned PerService   = PerServiceDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sidt_in_if.sink     req_i,
  sidt_out_if.source  rsp_o
);

  localparam int unsigned IdW   = $clog2(NumInstances);
  localparam int unsigned PtrW  = $clog2(NumInstances + 1);
  localparam int unsigned RunW  = $clog2(NumInstances + 1);
  localparam int unsigned SvcW  = (NumServices > 1) ? $clog2(NumServices) : 1;
  localparam int unsigned CntW  = $clog2(PerService + 1);
  localparam int unsigned Depth = NumServices * PerService;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned BitW  = $clog2(HashW);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_DECODE   = 11'b000_0000_0010,
    ST_ALLOC    = 11'b000_0000_0100,
    ST_SRCH_RD  = 11'b000_0000_1000,
    ST_SRCH_CMP = 11'b000_0001_0000,
    ST_SH_RD    = 11'b000_0010_0000,
    ST_SH_WR    = 11'b000_0100_0000,
    ST_DIV      = 11'b000_1000_0000,
    ST_LK_RD    = 11'b001_0000_0000,
    ST_LK_WAIT  = 11'b010_0000_0000,
    ST_EMIT     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Table state
  inst_e           inst_status_q [NumInstances];
  logic [SvcW-1:0] inst_svc_q    [NumInstances];
  logic [CntW-1:0] svc_count_q   [NumServices];
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [RunW-1:0] run_q, run_d;

  // Command in work
  kind_e              kind_q;
  logic               use_q;
  logic [IdInW-1:0]   iid_q;
  logic [SvcInW-1:0]  sid_q;
  logic [HashW-1:0]   hash_q, hash_d;
  logic [SvcW-1:0]    svc_q, svc_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    k_q, k_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [BitW-1:0]    bit_q, bit_d;
  res_e               res_status_q, res_status_d;
  logic [ResIdW-1:0]  res_id_q, res_id_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  res_e               out_status_q;
  logic [ResIdW-1:0]  out_id_q;
  logic [TotalW-1:0]  out_total_q;
  logic               out_load;

  // Table write controls
  logic            stat_we;
  logic [IdW-1:0]  stat_idx;
  inst_e           stat_val;
  logic            isvc_we;
  logic [SvcW-1:0] isvc_val;
  logic            cnt_we;
  logic [SvcW-1:0] cnt_idx;
  logic [CntW-1:0] cnt_val;

  // Member RAM
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [IdW-1:0]   mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [IdW-1:0]   mem_rdata;

  // Decode helpers
  logic            iid_ok, sid_ok;
  logic [IdW-1:0]  iid_idx;
  logic [SvcW-1:0] sid_idx, svc_sel;
  logic [CntW-1:0] cnt_sel;
  logic [AddrW-1:0] svc_base;
  logic [CntW:0]   trial;
  logic [IdW-1:0]  alloc_id;
  logic            stop_done, stop_shrink;

  assign iid_ok   = 32'(iid_q) < NumInstances;
  assign sid_ok   = 32'(sid_q) < NumServices;
  assign iid_idx  = IdW'(iid_q);
  assign sid_idx  = SvcW'(sid_q);
  assign svc_sel  = (kind_q == KIND_STOP) ? inst_svc_q[iid_idx] : sid_idx;
  assign cnt_sel  = svc_count_q[svc_sel];
  assign svc_base = AddrW'(32'(svc_q) * PerService);
  assign trial    = {rem_q, hash_q[HashW-1]};
  assign alloc_id = IdW'(ptr_q);

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.result_id     = out_id_q;
  assign rsp_o.running_total = out_total_q;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    run_d        = run_q;
    hash_d       = hash_q;
    svc_d        = svc_q;
    n_d          = n_q;
    k_d          = k_q;
    rem_d        = rem_q;
    bit_d        = bit_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    stat_we      = 1'b0;
    stat_idx     = iid_idx;
    stat_val     = INST_STARTING;
    isvc_we      = 1'b0;
    isvc_val     = '0;
    cnt_we       = 1'b0;
    cnt_idx      = svc_sel;
    cnt_val      = cnt_sel + 1'b1;
    mem_we       = 1'b0;
    mem_waddr    = AddrW'(32'(svc_sel) * PerService + 32'(cnt_sel));
    mem_wdata    = iid_idx;
    mem_raddr    = svc_base + AddrW'(k_q);
    stop_done    = 1'b0;
    stop_shrink  = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          hash_d  = req_i.rss_hash;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        svc_d   = svc_sel;
        n_d     = cnt_sel;
        k_d     = '0;
        rem_d   = '0;
        bit_d   = BitW'(HashW - 1);
        state_d = ST_EMIT;
        res_id_d = NoneId;
        case (kind_q)
          KIND_START: begin
            if (!use_q) begin
              state_d = ST_ALLOC;
            end else if (!iid_ok) begin
              res_status_d = RES_NO_IDS;
            end else if (inst_status_q[iid_idx] == INST_RUNNING) begin
              res_status_d = RES_CONFLICT;
            end else begin
              stat_we      = 1'b1;
              res_status_d = RES_OK;
              res_id_d     = ResIdW'(iid_q);
            end
          end
          KIND_READY: begin
            if (!iid_ok || !sid_ok || inst_status_q[iid_idx] != INST_STARTING) begin
              res_status_d = RES_WRONG;
            end else if (cnt_sel >= CntW'(PerService)) begin
              res_status_d = RES_FULL;
            end else begin
              stat_we      = 1'b1;
              stat_val     = INST_RUNNING;
              isvc_we      = 1'b1;
              isvc_val     = sid_idx;
              cnt_we       = 1'b1;
              mem_we       = 1'b1;
              run_d        = run_q + 1'b1;
              res_status_d = RES_OK;
              res_id_d     = ResIdW'(iid_q);
            end
          end
          KIND_STOP: begin
            if (!iid_ok || inst_status_q[iid_idx] != INST_RUNNING) begin
              res_status_d = RES_WRONG;
            end else if (cnt_sel == '0) begin
              stop_done = 1'b1;
            end else begin
              state_d = ST_SRCH_RD;
            end
          end
          default: begin
            if (!sid_ok) begin
              res_status_d = RES_WRONG;
            end else if (cnt_sel == '0) begin
              res_status_d = RES_OK;
              res_id_d     = '0;
            end else begin
              state_d = ST_DIV;
            end
          end
        endcase
      end

      ST_ALLOC: begin
        res_id_d = NoneId;
        if (ptr_q >= PtrW'(NumInstances)) begin
          res_status_d = RES_NO_IDS;
          state_d      = ST_EMIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
          if (inst_status_q[alloc_id] != INST_RUNNING) begin
            stat_we      = 1'b1;
            stat_idx     = alloc_id;
            res_status_d = RES_OK;
            res_id_d     = ResIdW'(ptr_q);
            state_d      = ST_EMIT;
          end else if (ptr_q == PtrW'(NumInstances - 1)) begin
            // last id taken was running: the walk ends on a conflict
            res_status_d = RES_CONFLICT;
            state_d      = ST_EMIT;
          end
        end
      end

      ST_SRCH_RD: begin
        state_d = ST_SRCH_CMP;
      end

      ST_SRCH_CMP: begin
        if (mem_rdata == iid_idx) begin
          if ((k_q + 1'b1) < n_q) begin
            state_d = ST_SH_RD;
          end else begin
            stop_shrink = 1'b1;
            stop_done   = 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
          if ((k_q + 1'b1) >= n_q) begin
            stop_done = 1'b1;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end

      ST_SH_RD: begin
        mem_raddr = svc_base + AddrW'(k_q) + 1'b1;
        state_d   = ST_SH_WR;
      end

      ST_SH_WR: begin
        // move the next member up by one place
        mem_we    = 1'b1;
        mem_waddr = svc_base + AddrW'(k_q);
        mem_wdata = mem_rdata;
        k_d       = k_q + 1'b1;
        if ((CntW'(k_q) + CntW'(2)) < n_q) begin
          state_d = ST_SH_RD;
        end else begin
          stop_shrink = 1'b1;
          stop_done   = 1'b1;
        end
      end

      ST_DIV: begin
        hash_d = {hash_q[HashW-2:0], 1'b0};
        if (trial >= {1'b0, n_q}) begin
          rem_d = CntW'(trial - {1'b0, n_q});
        end else begin
          rem_d = CntW'(trial);
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = ST_LK_RD;
        end
      end

      ST_LK_RD: begin
        mem_raddr = svc_base + AddrW'(rem_q);
        state_d   = ST_LK_WAIT;
      end

      ST_LK_WAIT: begin
        res_status_d = RES_OK;
        res_id_d     = ResIdW'(mem_rdata);
        state_d      = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (stop_done) begin
      stat_we      = 1'b1;
      stat_val     = INST_FREE;
      isvc_we      = 1'b1;
      isvc_val     = '0;
      if (run_q != '0) begin
        run_d = run_q - 1'b1;
      end
      res_status_d = RES_OK;
      res_id_d     = ResIdW'(iid_q);
      state_d      = ST_EMIT;
    end
    if (stop_shrink) begin
      cnt_we  = 1'b1;
      cnt_idx = svc_q;
      cnt_val = n_q - 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumInstances; i++) begin
        inst_status_q[i] <= INST_FREE;
        inst_svc_q[i]    <= '0;
      end
      for (int s = 0; s < NumServices; s++) begin
        svc_count_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (stat_we) begin
        inst_status_q[stat_idx] <= stat_val;
      end
      if (isvc_we) begin
        inst_svc_q[iid_idx] <= isvc_val;
      end
      if (cnt_we) begin
        svc_count_q[cnt_idx] <= cnt_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      kind_q <= kind_e'(req_i.kind);
      use_q  <= req_i.use_requested;
      iid_q  <= req_i.inst_id;
      sid_q  <= req_i.svc_id;
    end
    hash_q       <= hash_d;
    svc_q        <= svc_d;
    n_q          <= n_d;
    k_q          <= k_d;
    rem_q        <= rem_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_total_q  <= TotalW'(run_q);
    end
  end

  sidt_ram #(
    .Width (IdW),
    .Depth (Depth)
  ) u_members (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `SIDT_ASSERT(a_busy_after_take, req_i.valid && req_i.ready |=> state_q != ST_IDLE,
    "sequencer idle right after a request transfer")
  `SIDT_ASSERT(a_run_bound, 32'(run_q) <= NumInstances,
    "running count above the number of instances")
  `SIDT_ASSERT(a_rem_bound, state_q == ST_LK_RD |-> rem_q < n_q,
    "lookup index outside the service list")
  `SIDT_ASSERT_ALWAYS(a_onehot_state, !rst_ni || $onehot(state_q),
    "sequencer state not one-hot")

endmodule
